@@ hdl/tte_pkg.sv @@
package tte_pkg;

  localparam int DIMS      = 4;
  localparam int REG_W     = 11;
  localparam int IDX_W     = 3;
  localparam int DATA_W    = 64;
  localparam int SRC_W     = 10;
  localparam int OUT_W     = 20;
  localparam int EXT_W     = 21;
  localparam int STEP_W    = 2;
  localparam int DIM_LIMIT = 1024;

  localparam logic [IDX_W-1:0] REG_SIZE_0   = 3'd0;
  localparam logic [IDX_W-1:0] REG_SIZE_1   = 3'd1;
  localparam logic [IDX_W-1:0] REG_SIZE_2   = 3'd2;
  localparam logic [IDX_W-1:0] REG_SIZE_3   = 3'd3;
  localparam logic [IDX_W-1:0] REG_REPEAT_0 = 3'd4;
  localparam logic [IDX_W-1:0] REG_REPEAT_1 = 3'd5;
  localparam logic [IDX_W-1:0] REG_REPEAT_2 = 3'd6;
  localparam logic [IDX_W-1:0] REG_REPEAT_3 = 3'd7;

  typedef enum logic [1:0] {
    ST_CALC = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef struct packed {
    logic              calc;
    logic [STEP_W-1:0] calc_step;
    logic              load;
    logic              emit;
  } cmd_t;

  typedef struct packed {
    logic do_load;
    logic do_emit;
  } status_t;

  // clamp a size or repeat register to 1..DIM_LIMIT
  function automatic logic [REG_W-1:0] eff_reg(input logic [REG_W-1:0] v);
    logic [REG_W-1:0] r;
    if (v == '0) begin
      r = REG_W'(1);
    end else if (v > REG_W'(DIM_LIMIT)) begin
      r = REG_W'(DIM_LIMIT);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ hdl/tte_in_if.sv @@
interface tte_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [tte_pkg::DATA_W-1:0]  element_value;

  modport source (output valid, output kind, output element_value, input ready);
  modport sink   (input valid, input kind, input element_value, output ready);
endinterface

@@ hdl/tte_out_if.sv @@
interface tte_out_if;
  logic                        valid;
  logic                        ready;
  logic [tte_pkg::DATA_W-1:0]  output_value;
  logic                        last_element;

  modport source (output valid, output output_value, output last_element, input ready);
  modport sink   (input valid, input output_value, input last_element, output ready);
endinterface

@@ hdl/tensor_tile_expand_unit.sv @@
// Tensor tile expander: tiles a tensor of up to four dimensions.
// Channel item (valid/ready): kind 0 loads element_value into the element
// store in row-major order; kind 1 requests the next tiled output element.
// Channel result (valid/ready): output_value and last_element, one per emit
// that finds the whole input loaded; loads and early emits give no result.
// Config port: cfg_we, cfg_index (sizes 0..3, then repeats 0..3), cfg_data.
// Any write restarts the load count and the output coordinates; stored data
// is kept.
// A result appears in the cycle after its emit transaction, the store read
// port being registered. Throughput: one transaction per cycle while
// the result channel keeps up, with one store read and one coordinate step
// per emit.
// After reset and after every config write the block computes element count,
// strides and extents with one multiplier step per dimension; item.ready is
// low during that time.
// A stalled result holds; item.ready drops until the held result is taken.
module tensor_tile_expand_unit #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int MAX_RANK     = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [tte_pkg::IDX_W-1:0]   cfg_index,
  input  logic [tte_pkg::REG_W-1:0]   cfg_data,
  tte_in_if.sink                      item,
  tte_out_if.source                   result
);

  import tte_pkg::*;

  cmd_t    cmd;
  status_t st;

  tte_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .item_valid   (item.valid),
    .result_ready (result.ready),
    .st           (st),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .cmd          (cmd)
  );

  tte_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .MAX_RANK     (MAX_RANK)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .kind          (item.kind),
    .element_value (item.element_value),
    .cmd           (cmd),
    .st            (st),
    .output_value  (result.output_value),
    .last_element  (result.last_element)
  );

endmodule

@@ hdl/tte_ram.sv @@
module tte_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/tte_ctrl.sv @@
module tte_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              item_valid,
  input  logic              result_ready,
  input  tte_pkg::status_t  st,
  output logic              item_ready,
  output logic              result_valid,
  output tte_pkg::cmd_t     cmd
);

  import tte_pkg::*;

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              out_valid, out_valid_next;
  logic              take;

  assign item_ready   = (state == ST_RUN) && (!out_valid || result_ready);
  assign result_valid = out_valid;
  assign take         = item_valid && item_ready;

  always_comb begin
    cmd.calc      = (state == ST_CALC);
    cmd.calc_step = step;
    cmd.load      = take && st.do_load;
    cmd.emit      = take && st.do_emit;
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      ST_CALC: begin
        step_next = step + STEP_W'(1);
        if (step == STEP_W'(DIMS - 1)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        step_next = '0;
      end
      default: begin
        state_next = ST_CALC;
        step_next  = '0;
      end
    endcase
    if (cfg_we) begin
      state_next = ST_CALC;
      step_next  = '0;
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (result_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CALC;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ hdl/tte_datapath.sv @@
module tte_datapath #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int MAX_RANK     = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tte_pkg::IDX_W-1:0]     cfg_index,
  input  logic [tte_pkg::REG_W-1:0]     cfg_data,
  input  logic                          kind,
  input  logic [tte_pkg::DATA_W-1:0]    element_value,
  input  tte_pkg::cmd_t                 cmd,
  output tte_pkg::status_t              st,
  output logic [tte_pkg::DATA_W-1:0]    output_value,
  output logic                          last_element
);

  import tte_pkg::*;

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 2);
  localparam int LW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] CAP   = CW'(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] MAXEL = CW'(MAX_ELEMENTS);

  logic [REG_W-1:0] size_reg [DIMS];
  logic [REG_W-1:0] rep_reg  [DIMS];
  logic [REG_W-1:0] eff_size [DIMS];
  logic [REG_W-1:0] eff_rep  [DIMS];

  logic [EXT_W-1:0] ext    [DIMS];
  logic [CW-1:0]    stride [DIMS];
  logic [CW-1:0]    acc;

  logic [LW-1:0]    load_count;
  logic [OUT_W-1:0] out_idx [DIMS];
  logic [SRC_W-1:0] src_idx [DIMS];
  logic [CW-1:0]    off     [DIMS];

  logic [STEP_W-1:0]     cd;
  logic [CW-1:0]         acc_in;
  logic [CW+REG_W-1:0]   prod;
  logic [2*REG_W-1:0]    ext_prod;
  logic [CW-1:0]         load_ext;
  logic [CW-1:0]         addr;
  logic [DIMS-1:0]       lt, sel, clr;
  logic                  found;
  logic                  last_q;

  always_comb begin
    for (int d = 0; d < DIMS; d++) begin
      if (d < DIMS - MAX_RANK) begin
        eff_size[d] = REG_W'(1);
        eff_rep[d]  = REG_W'(1);
      end else begin
        eff_size[d] = eff_reg(size_reg[d]);
        eff_rep[d]  = eff_reg(rep_reg[d]);
      end
    end
  end

  // element count, strides and extents, innermost dimension first, count saturated above capacity
  assign cd       = STEP_W'(DIMS - 1) - cmd.calc_step;
  assign acc_in   = (cmd.calc_step == '0) ? CW'(1) : acc;
  assign prod     = acc_in * eff_size[cd];
  assign ext_prod = eff_size[cd] * eff_rep[cd];

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      acc         <= (prod > (CW+REG_W)'(CAP)) ? CAP : prod[CW-1:0];
      stride[cd]  <= acc_in;
      ext[cd]     <= ext_prod[EXT_W-1:0];
    end
  end

  assign load_ext   = CW'(load_count);
  assign st.do_load = !kind && (load_ext < acc) && (load_ext < MAXEL);
  assign st.do_emit = kind && (acc <= MAXEL) && (load_ext >= acc);

  always_comb begin
    addr  = '0;
    found = 1'b0;
    sel   = '0;
    clr   = '0;
    for (int d = 0; d < DIMS; d++) begin
      addr  = addr + off[d];
      lt[d] = ({1'b0, out_idx[d]} + EXT_W'(1)) < ext[d];
    end
    for (int d = DIMS - 1; d >= 0; d--) begin
      if (!found) begin
        if (lt[d]) begin
          sel[d] = 1'b1;
        end else begin
          clr[d] = 1'b1;
        end
      end
      found = found | lt[d];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < DIMS; d++) begin
        size_reg[d] <= REG_W'(1);
        rep_reg[d]  <= REG_W'(1);
        out_idx[d]  <= '0;
        src_idx[d]  <= '0;
        off[d]      <= '0;
      end
      load_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIZE_0:   size_reg[0] <= cfg_data;
        REG_SIZE_1:   size_reg[1] <= cfg_data;
        REG_SIZE_2:   size_reg[2] <= cfg_data;
        REG_SIZE_3:   size_reg[3] <= cfg_data;
        REG_REPEAT_0: rep_reg[0]  <= cfg_data;
        REG_REPEAT_1: rep_reg[1]  <= cfg_data;
        REG_REPEAT_2: rep_reg[2]  <= cfg_data;
        REG_REPEAT_3: rep_reg[3]  <= cfg_data;
        default: ;
      endcase
      for (int d = 0; d < DIMS; d++) begin
        out_idx[d] <= '0;
        src_idx[d] <= '0;
        off[d]     <= '0;
      end
      load_count <= '0;
    end else begin
      if (cmd.load) begin
        load_count <= load_count + LW'(1);
      end
      if (cmd.emit) begin
        for (int d = 0; d < DIMS; d++) begin
          if (sel[d]) begin
            out_idx[d] <= out_idx[d] + OUT_W'(1);
            if (({1'b0, src_idx[d]} + (SRC_W+1)'(1)) < (SRC_W+1)'(eff_size[d])) begin
              src_idx[d] <= src_idx[d] + SRC_W'(1);
              off[d]     <= off[d] + stride[d];
            end else begin
              src_idx[d] <= '0;
              off[d]     <= '0;
            end
          end else if (clr[d]) begin
            out_idx[d] <= '0;
            src_idx[d] <= '0;
            off[d]     <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last_q <= ~|lt;
    end
  end

  assign last_element = last_q;

  tte_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ELEMENTS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (load_count[AW-1:0]),
    .wdata (element_value),
    .re    (cmd.emit),
    .raddr (addr[AW-1:0]),
    .rdata (output_value)
  );

endmodule
